@@ rtl/skt_pkg.sv @@
// shared types, constants and codes of the sorted key table
package skt_pkg;

   localparam int TABLE_DEPTH  = 64;
   localparam int KEY_BITS     = 32;
   localparam int PAYLOAD_BITS = 32;
   localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);
   localparam int KIND_BITS    = 2;
   localparam int POS_BITS     = 7;
   localparam int STATUS_BITS  = 2;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd2;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NO_MATCH = 2'd2;

   typedef struct packed {
      logic [1:0]              op;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } item_type;

   typedef struct packed {
      logic                    en;
      logic                    ins;
      logic [CNT_BITS-1:0]     pos;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } upd_type;

endpackage

@@ rtl/skt_ifs.sv @@
// handshake channels of the sorted key table

interface skt_req_if;
   logic                             valid;
   logic                             ready;
   logic [skt_pkg::KIND_BITS-1:0]    kind;
   logic [skt_pkg::KEY_BITS-1:0]     key;
   logic [skt_pkg::PAYLOAD_BITS-1:0] payload;

   modport source (output valid, kind, key, payload, input ready);
   modport sink (input valid, kind, key, payload, output ready);
endinterface

interface skt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [skt_pkg::PAYLOAD_BITS-1:0] found_payload;
   logic [skt_pkg::POS_BITS-1:0]     position;
   logic [skt_pkg::STATUS_BITS-1:0]  status;
   logic [skt_pkg::POS_BITS-1:0]     entries_held;

   modport source (output valid, hit, found_payload, position, status, entries_held,
                   input ready);
   modport sink (input valid, hit, found_payload, position, status, entries_held,
                 output ready);
endinterface

@@ rtl/sorted_key_table_top.sv @@
// top level of the sorted key table
//
// Keeps up to 64 (key, payload) entries in ascending unsigned key order.
// req_if carries one request word: kind (0 insert, 1 remove, 2 lookup, 3 as
// lookup), key and payload. rsp_if returns exactly one response word per
// request, in request order: hit, found_payload, position, status and the
// number of entries held afterwards.
// Requests enter a two-word queue, so req_if.ready stays high until two
// requests wait. The back end takes one request at a time: it loads the
// request, registers the per-entry key compares, runs the binary search at
// one probe per cycle (up to 7 probes at 64 entries, plus a closing step)
// and then updates the entries and loads the response register. The shift
// of an insert or remove happens across all entries in the same cycle.
// A stalled rsp_if holds its response word; the back end keeps working on the
// next request and waits only when a second response is ready.
// Reset empties the table and the queue; entry contents are not cleared.
module sorted_key_table_top (
   input  logic      clock,
   input  logic      reset,
   skt_req_if.sink   req_if,
   skt_rsp_if.source rsp_if
);

   logic                             pop_valid;
   logic                             pop_ready;
   skt_pkg::item_type                pop_item;
   logic [skt_pkg::KEY_BITS-1:0]     cmp_key;
   skt_pkg::upd_type                 upd;
   logic [skt_pkg::IDX_BITS-1:0]     rd_idx;
   logic [skt_pkg::PAYLOAD_BITS-1:0] rd_payload;
   logic [skt_pkg::TABLE_DEPTH-1:0]  lt_vec;
   logic [skt_pkg::TABLE_DEPTH-1:0]  eq_vec;

   skt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item)
   );

   skt_cells u_cells (
      .clock      (clock),
      .cmp_key    (cmp_key),
      .upd        (upd),
      .rd_idx     (rd_idx),
      .rd_payload (rd_payload),
      .lt_vec     (lt_vec),
      .eq_vec     (eq_vec)
   );

   skt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .cmp_key    (cmp_key),
      .upd        (upd),
      .rd_idx     (rd_idx),
      .rd_payload (rd_payload),
      .lt_vec     (lt_vec),
      .eq_vec     (eq_vec),
      .rsp_if     (rsp_if)
   );

endmodule

@@ rtl/skt_front.sv @@
// front end: takes request words, decodes the operation and queues them
module skt_front (
   input  logic               clock,
   input  logic               reset,
   skt_req_if.sink            req_if,
   output logic               pop_valid,
   input  logic               pop_ready,
   output skt_pkg::item_type  pop_item
);

   skt_pkg::item_type                queue_ff [skt_pkg::QUEUE_DEPTH];
   logic [skt_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [skt_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [skt_pkg::QCNT_BITS-1:0]    fill_ff, fill_in;
   logic                             push, pop;
   skt_pkg::item_type                new_item;

   always_comb begin
      new_item.key     = req_if.key;
      new_item.payload = req_if.payload;
      case (req_if.kind)
         skt_pkg::KIND_INSERT: new_item.op = skt_pkg::OP_INSERT;
         skt_pkg::KIND_REMOVE: new_item.op = skt_pkg::OP_REMOVE;
         default:              new_item.op = skt_pkg::OP_LOOKUP;
      endcase
   end

   assign req_if.ready = (fill_ff != skt_pkg::QCNT_BITS'(skt_pkg::QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign pop_valid    = (fill_ff != '0);
   assign pop          = pop_valid && pop_ready;
   assign pop_item     = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == skt_pkg::QPTR_BITS'(skt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == skt_pkg::QPTR_BITS'(skt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/skt_cells.sv @@
// sorted entry cells: per-entry key compare and a shift of all entries at once on insert or remove
module skt_cells (
   input  logic                             clock,
   input  logic [skt_pkg::KEY_BITS-1:0]     cmp_key,
   input  skt_pkg::upd_type                 upd,
   input  logic [skt_pkg::IDX_BITS-1:0]     rd_idx,
   output logic [skt_pkg::PAYLOAD_BITS-1:0] rd_payload,
   output logic [skt_pkg::TABLE_DEPTH-1:0]  lt_vec,
   output logic [skt_pkg::TABLE_DEPTH-1:0]  eq_vec
);

   logic [skt_pkg::KEY_BITS-1:0]     key_ff [skt_pkg::TABLE_DEPTH];
   logic [skt_pkg::PAYLOAD_BITS-1:0] pay_ff [skt_pkg::TABLE_DEPTH];
   logic [skt_pkg::TABLE_DEPTH-1:0]  lt_ff, eq_ff;

   assign lt_vec     = lt_ff;
   assign eq_vec     = eq_ff;
   assign rd_payload = pay_ff[rd_idx];

   // cell key below / equal to the search key
   always_ff @(posedge clock) begin
      for (int i = 0; i < skt_pkg::TABLE_DEPTH; i++) begin
         lt_ff[i] <= (key_ff[i] < cmp_key);
         eq_ff[i] <= (key_ff[i] == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      if (upd.en) begin
         for (int i = 0; i < skt_pkg::TABLE_DEPTH; i++) begin
            if (upd.ins) begin
               if (skt_pkg::CNT_BITS'(i) == upd.pos) begin
                  key_ff[i] <= upd.key;
                  pay_ff[i] <= upd.payload;
               end else if ((skt_pkg::CNT_BITS'(i) > upd.pos) && (i > 0)) begin
                  key_ff[i] <= key_ff[(i > 0) ? i - 1 : 0];
                  pay_ff[i] <= pay_ff[(i > 0) ? i - 1 : 0];
               end
            end else if ((skt_pkg::CNT_BITS'(i) >= upd.pos) &&
                         (i < skt_pkg::TABLE_DEPTH - 1)) begin
               key_ff[i] <= key_ff[(i < skt_pkg::TABLE_DEPTH - 1) ? i + 1 : i];
               pay_ff[i] <= pay_ff[(i < skt_pkg::TABLE_DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

endmodule

@@ rtl/skt_back.sv @@
// back end: binary search sequencer, table update and response register
module skt_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  skt_pkg::item_type                pop_item,
   output logic [skt_pkg::KEY_BITS-1:0]     cmp_key,
   output skt_pkg::upd_type                 upd,
   output logic [skt_pkg::IDX_BITS-1:0]     rd_idx,
   input  logic [skt_pkg::PAYLOAD_BITS-1:0] rd_payload,
   input  logic [skt_pkg::TABLE_DEPTH-1:0]  lt_vec,
   input  logic [skt_pkg::TABLE_DEPTH-1:0]  eq_vec,
   skt_rsp_if.source                        rsp_if
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CMP    = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]                       state_ff, state_in;
   skt_pkg::item_type                op_ff, op_in;
   logic [skt_pkg::CNT_BITS-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [skt_pkg::CNT_BITS-1:0]     count_ff, count_in;
   logic                             found_ff, found_in;
   logic [skt_pkg::CNT_BITS:0]       mid_sum;
   logic [skt_pkg::CNT_BITS-1:0]     mid;
   logic [skt_pkg::IDX_BITS-1:0]     mid_idx;
   logic                             rsp_free;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_hit_ff, rsp_hit_in;
   logic [skt_pkg::PAYLOAD_BITS-1:0] rsp_pay_ff, rsp_pay_in;
   logic [skt_pkg::POS_BITS-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [skt_pkg::STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [skt_pkg::POS_BITS-1:0]     rsp_held_ff, rsp_held_in;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[skt_pkg::CNT_BITS:1];
   assign mid_idx   = mid[skt_pkg::IDX_BITS-1:0];
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign pop_ready = (state_ff == S_IDLE);
   assign cmp_key   = op_ff.key;
   assign rd_idx    = lo_ff[skt_pkg::IDX_BITS-1:0];

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.hit           = rsp_hit_ff;
   assign rsp_if.found_payload = rsp_pay_ff;
   assign rsp_if.position      = rsp_pos_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.entries_held  = rsp_held_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_held_in   = rsp_held_ff;
      upd.en        = 1'b0;
      upd.ins       = (op_ff.op == skt_pkg::OP_INSERT);
      upd.pos       = lo_ff;
      upd.key       = op_ff.key;
      upd.payload   = op_ff.payload;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               op_in    = pop_item;
               lo_in    = '0;
               hi_in    = count_ff;
               found_in = 1'b0;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            // the search position ends up in lo
            if (lo_ff < hi_ff) begin
               if (eq_vec[mid_idx]) begin
                  found_in = 1'b1;
                  lo_in    = mid;
                  state_in = S_DONE;
               end else if (lt_vec[mid_idx]) begin
                  lo_in = mid + 1'b1;
               end else begin
                  hi_in = mid;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         default: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pos_in    = skt_pkg::POS_BITS'(lo_ff);
               rsp_status_in = skt_pkg::ST_DONE;
               rsp_pay_in    = '0;
               rsp_hit_in    = found_ff;
               case (op_ff.op)
                  skt_pkg::OP_INSERT: begin
                     if (count_ff == skt_pkg::CNT_BITS'(skt_pkg::TABLE_DEPTH)) begin
                        rsp_status_in = skt_pkg::ST_FULL;
                     end else begin
                        upd.en   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  skt_pkg::OP_REMOVE: begin
                     if (found_ff) begin
                        rsp_pay_in = rd_payload;
                        upd.en     = 1'b1;
                        count_in   = count_ff - 1'b1;
                     end else begin
                        rsp_status_in = skt_pkg::ST_NO_MATCH;
                     end
                  end
                  default: begin
                     if (found_ff) begin
                        rsp_pay_in = rd_payload;
                     end
                  end
               endcase
               rsp_held_in = skt_pkg::POS_BITS'(count_in);
               state_in    = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      found_ff      <= found_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_held_ff   <= rsp_held_in;
   end

endmodule
